// File: rtl/core/lwnxdf_pkg.sv
`timescale 1ns / 1ps

package lwnxdf_pkg;

    localparam logic [7:0] START_BYTE = 8'hAA;

    typedef enum logic [1:0] {
        PH_HUNT     = 2'd0,
        PH_FLAGS_LO = 2'd1,
        PH_FLAGS_HI = 2'd2,
        PH_BODY     = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_COLLECT  = 2'd0,
        ST_GOOD     = 2'd1,
        ST_CRC_BAD  = 2'd2,
        ST_TOO_LONG = 2'd3
    } status_t;

    // One result item, as produced by the parser and held in the output stage
    typedef struct packed {
        logic [9:0] payload_length;
        logic       write_flag;
        logic [7:0] command_id;
        logic       in_packet;
        logic [9:0] byte_position;
        logic [7:0] echo_byte;
        logic       command_match;
        status_t    status;
    } result_t;

    // CRC-16/XMODEM, poly 0x1021, one byte per call (nibble-folded form)
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc[15:8] ^ b;
        c = c ^ (c >> 4);
        return {crc[7:0], 8'h00} ^ {8'h00, c} ^ {3'b000, c, 5'b00000} ^ {c[3:0], 12'h000};
    endfunction

endpackage

// File: rtl/core/lwnxdf_parser.sv
`timescale 1ns / 1ps

module lwnxdf_parser
    import lwnxdf_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 1019
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  logic [7:0]    rx_byte,
    input  logic [7:0]    wanted_command,
    output result_t       result
);

    phase_t      phase_reg,      phase_next;
    logic [7:0]  flags_low_reg,  flags_low_next;
    logic [10:0] bytes_left_reg, bytes_left_next;
    logic [9:0]  position_reg,   position_next;
    logic [15:0] crc_reg,        crc_next;
    logic [7:0]  crc_low_reg,    crc_low_next;
    logic [7:0]  command_reg,    command_next;
    logic        write_reg,      write_next;
    logic [9:0]  length_reg,     length_next;

    logic [10:0] left;
    logic [15:0] crc_in;
    logic [15:0] crc_upd;
    logic [15:0] crc_got;

    // one CRC update shared by every phase that feeds a byte
    assign crc_in  = (phase_reg == PH_HUNT) ? 16'h0000 : crc_reg;
    assign crc_upd = crc_feed(crc_in, rx_byte);
    assign crc_got = {rx_byte, crc_low_reg};

    always_comb begin
        logic [10:0] tot;
        phase_next      = phase_reg;
        flags_low_next  = flags_low_reg;
        bytes_left_next = bytes_left_reg;
        position_next   = position_reg;
        crc_next        = crc_reg;
        crc_low_next    = crc_low_reg;
        command_next    = command_reg;
        write_next      = write_reg;
        length_next     = length_reg;
        left            = bytes_left_reg;
        tot             = {1'b0, rx_byte, flags_low_reg[7:6]} + 11'd2;

        result.status        = ST_COLLECT;
        result.command_match = 1'b0;
        result.echo_byte     = rx_byte;
        result.byte_position = 10'd0;
        result.in_packet     = 1'b1;

        unique case (phase_reg)
            PH_HUNT: begin
                command_next = 8'h00;
                write_next   = 1'b0;
                length_next  = 10'd0;
                if (rx_byte == START_BYTE) begin
                    crc_next   = crc_upd;
                    phase_next = PH_FLAGS_LO;
                end else begin
                    result.in_packet = 1'b0;
                end
            end
            PH_FLAGS_LO: begin
                flags_low_next       = rx_byte;
                crc_next             = crc_upd;
                result.byte_position = 10'd1;
                phase_next           = PH_FLAGS_HI;
            end
            PH_FLAGS_HI: begin
                result.byte_position = 10'd2;
                crc_next             = crc_upd;
                length_next          = {rx_byte, flags_low_reg[7:6]};
                write_next           = flags_low_reg[0];
                bytes_left_next      = tot;
                position_next        = 10'd3;
                if (tot > 11'(MAX_PAYLOAD)) begin
                    result.status = ST_TOO_LONG;
                    phase_next    = PH_HUNT;
                end else begin
                    phase_next    = PH_BODY;
                end
            end
            PH_BODY: begin
                result.byte_position = position_reg;
                if (position_reg == 10'd3) begin
                    command_next = rx_byte;
                end
                if (bytes_left_reg != 11'd0) begin
                    left = bytes_left_reg - 11'd1;
                end
                bytes_left_next = left;
                position_next   = position_reg + 10'd1;
                if (left >= 11'd2) begin
                    crc_next = crc_upd;
                end else if (left == 11'd1) begin
                    crc_low_next = rx_byte;
                end else begin
                    // last CRC byte: check against the running value
                    if (crc_got == crc_reg) begin
                        result.status        = ST_GOOD;
                        result.command_match = (command_next == wanted_command);
                    end else begin
                        result.status = ST_CRC_BAD;
                    end
                    phase_next = PH_HUNT;
                end
            end
        endcase

        result.command_id     = command_next;
        result.write_flag     = write_next;
        result.payload_length = length_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            flags_low_reg  <= 8'h00;
            bytes_left_reg <= 11'd0;
            position_reg   <= 10'd0;
            crc_reg        <= 16'h0000;
            crc_low_reg    <= 8'h00;
            command_reg    <= 8'h00;
            write_reg      <= 1'b0;
            length_reg     <= 10'd0;
        end else if (step) begin
            phase_reg      <= phase_next;
            flags_low_reg  <= flags_low_next;
            bytes_left_reg <= bytes_left_next;
            position_reg   <= position_next;
            crc_reg        <= crc_next;
            crc_low_reg    <= crc_low_next;
            command_reg    <= command_next;
            write_reg      <= write_next;
            length_reg     <= length_next;
        end
    end

    // a packet may only leave the body phase on its last CRC byte
    property p_body_exit;
        @(posedge aclk) disable iff (!aresetn)
            (step && phase_reg == PH_BODY && phase_next == PH_HUNT)
                |-> (bytes_left_reg <= 11'd1);
    endproperty
    a_body_exit: assert property (p_body_exit) else $error("body left early");

    property p_match_good;
        @(posedge aclk) disable iff (!aresetn)
            result.command_match |-> (result.status == ST_GOOD);
    endproperty
    a_match_good: assert property (p_match_good) else $error("match on bad packet");

    property p_hold;
        @(posedge aclk) disable iff (!aresetn)
            !step |=> $stable(phase_reg) && $stable(crc_reg);
    endproperty
    a_hold: assert property (p_hold) else $error("state moved without a transaction");

endmodule

// File: rtl/core/lwnx_packet_deframer_crc16_unit.sv
`timescale 1ns / 1ps

// Byte-stream packet deframer with CRC-16/XMODEM check. One received byte per
// transaction on s_; every byte yields exactly one result on m_, registered
// first in the input register and then in the output register, where it
// waits while m_ is stalled. Throughput is one byte per cycle while m_ is not
// stalled: the parser's state registers update once per accepted byte. Packets
// start with 0xAA, carry a little-endian flags word (bit 0 write flag, bits
// 15..6 payload length), the payload and a little-endian CRC; packets whose
// length plus two exceeds MAX_PAYLOAD are reported as too long at the second
// flags byte. wanted_command is written through cfg_; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module lwnx_packet_deframer_crc16_unit
    import lwnxdf_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 1019
) (
    input  logic        aclk,
    input  logic        aresetn,
    // rx_byte[7:0]
    input  logic [7:0]  s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // status[1:0], command_match[2], echo_byte[10:3], byte_position[20:11],
    // in_packet[21], command_id[29:22], write_flag[30], payload_length[40:31]
    output logic [47:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  cfg_data,
    input  logic        cfg_valid,
    output logic        cfg_ready
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic [7:0] wanted_reg;
    logic       advance;
    result_t    result;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wanted_reg <= 8'h00;
        end else if (cfg_valid) begin
            wanted_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    lwnxdf_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .rx_byte       (in_byte_reg),
        .wanted_command(wanted_reg),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0000000, out_reg.payload_length, out_reg.write_flag,
                       out_reg.command_id, out_reg.in_packet, out_reg.byte_position,
                       out_reg.echo_byte, out_reg.command_match, out_reg.status};

    // the input stage must not drop a byte while the output is stalled
    property p_in_hold;
        @(posedge aclk) disable iff (!aresetn)
            (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg));
    endproperty
    a_in_hold: assert property (p_in_hold) else $error("input stage lost a byte");

    property p_out_load;
        @(posedge aclk) disable iff (!aresetn)
            advance |=> out_valid_reg;
    endproperty
    a_out_load: assert property (p_out_load) else $error("result not loaded");

    property p_hunt_pos;
        @(posedge aclk) disable iff (!aresetn)
            (out_valid_reg && !out_reg.in_packet) |->
                (out_reg.byte_position == 10'd0 && out_reg.command_id == 8'h00);
    endproperty
    a_hunt_pos: assert property (p_hunt_pos) else $error("hunting result has packet fields");

endmodule

// File: tb/sv/deframe_monitor.sv
`timescale 1ns / 1ps

package deframe_tb_pkg;

    // CRC-16/XMODEM, bitwise form: poly 0x1021, MSB first
    function automatic logic [15:0] crc_xmodem_step(input logic [15:0] crc,
                                                    input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
        end
        return r;
    endfunction

endpackage

module deframe_monitor
    import lwnxdf_pkg::*;
    import deframe_tb_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 1019
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_tdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  cfg_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    output int unsigned mismatches,
    output int unsigned pending,
    output int unsigned results_checked,
    output int unsigned good_packets,
    output int unsigned crc_errors,
    output int unsigned oversize_packets,
    output int unsigned command_matches
);

    // parser state as the block should hold it
    phase_t      parse_state;
    logic [7:0]  wanted_cmd;
    logic [7:0]  flags_lo;
    logic [10:0] left_count;
    logic [9:0]  pkt_pos;
    logic [15:0] crc;
    logic [7:0]  crc_lo;
    logic [7:0]  pkt_cmd;
    logic        pkt_wr;
    logic [9:0]  held_len;

    result_t expected_results[$];
    result_t want;
    result_t got;

    task automatic report_mismatch(input string what, input logic [15:0] seen,
                                   input logic [15:0] wanted);
        mismatches++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, what, seen, wanted);
    endtask

    function automatic result_t deframe_byte(input logic [7:0] b);
        result_t     r;
        logic [15:0] word;
        logic [10:0] total;
        logic [10:0] left;
        r = '0;
        r.status = ST_COLLECT;
        r.echo_byte = b;
        r.in_packet = 1'b1;
        case (parse_state)
            PH_HUNT: begin
                pkt_cmd = 8'h00;
                pkt_wr = 1'b0;
                held_len = 10'd0;
                if (b == START_BYTE) begin
                    crc = crc_xmodem_step(16'h0000, b);
                    parse_state = PH_FLAGS_LO;
                end else begin
                    r.in_packet = 1'b0;
                end
            end
            PH_FLAGS_LO: begin
                flags_lo = b;
                crc = crc_xmodem_step(crc, b);
                r.byte_position = 10'd1;
                parse_state = PH_FLAGS_HI;
            end
            PH_FLAGS_HI: begin
                word = {b, flags_lo};
                r.byte_position = 10'd2;
                crc = crc_xmodem_step(crc, b);
                held_len = word[15:6];
                pkt_wr = word[0];
                total = {1'b0, held_len} + 11'd2;
                left_count = total;
                pkt_pos = 10'd3;
                if (total > MAX_PAYLOAD) begin
                    r.status = ST_TOO_LONG;
                    parse_state = PH_HUNT;
                end else begin
                    parse_state = PH_BODY;
                end
            end
            default: begin
                left = left_count;
                r.byte_position = pkt_pos;
                if (pkt_pos == 10'd3)
                    pkt_cmd = b;
                if (left != 11'd0)
                    left = left - 11'd1;
                left_count = left;
                pkt_pos = pkt_pos + 10'd1;
                if (left >= 11'd2) begin
                    crc = crc_xmodem_step(crc, b);
                end else if (left == 11'd1) begin
                    crc_lo = b;
                end else begin
                    // last CRC byte: little-endian compare against the running value
                    r.status = ({b, crc_lo} == crc) ? ST_GOOD : ST_CRC_BAD;
                    r.command_match = (r.status == ST_GOOD) && (pkt_cmd == wanted_cmd);
                    parse_state = PH_HUNT;
                end
            end
        endcase
        r.command_id = pkt_cmd;
        r.write_flag = pkt_wr;
        r.payload_length = held_len;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            parse_state = PH_HUNT;
            wanted_cmd = 8'h00;
            flags_lo = 8'h00;
            left_count = 11'd0;
            pkt_pos = 10'd0;
            crc = 16'h0000;
            crc_lo = 8'h00;
            pkt_cmd = 8'h00;
            pkt_wr = 1'b0;
            held_len = 10'd0;
            expected_results.delete();
            mismatches = 0;
            results_checked = 0;
            good_packets = 0;
            crc_errors = 0;
            oversize_packets = 0;
            command_matches = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                wanted_cmd = cfg_data;
            if (s_tvalid && s_tready)
                expected_results.push_back(deframe_byte(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing outstanding", m_tdata[15:0], 16'h0);
                end else begin
                    want = expected_results.pop_front();
                    got = m_tdata[40:0];
                    results_checked++;
                    if (got.status != want.status)
                        report_mismatch("status", 16'(got.status), 16'(want.status));
                    if (got.command_match != want.command_match)
                        report_mismatch("command_match", 16'(got.command_match),
                                        16'(want.command_match));
                    if (got.echo_byte != want.echo_byte)
                        report_mismatch("echo_byte", 16'(got.echo_byte),
                                        16'(want.echo_byte));
                    if (got.byte_position != want.byte_position)
                        report_mismatch("byte_position", 16'(got.byte_position),
                                        16'(want.byte_position));
                    if (got.in_packet != want.in_packet)
                        report_mismatch("in_packet", 16'(got.in_packet),
                                        16'(want.in_packet));
                    if (got.command_id != want.command_id)
                        report_mismatch("command_id", 16'(got.command_id),
                                        16'(want.command_id));
                    if (got.write_flag != want.write_flag)
                        report_mismatch("write_flag", 16'(got.write_flag),
                                        16'(want.write_flag));
                    if (got.payload_length != want.payload_length)
                        report_mismatch("payload_length", 16'(got.payload_length),
                                        16'(want.payload_length));
                    if (m_tdata[47:41] != 7'd0)
                        report_mismatch("tdata padding", 16'(m_tdata[47:41]), 16'h0);
                    case (want.status)
                        ST_GOOD:     good_packets++;
                        ST_CRC_BAD:  crc_errors++;
                        ST_TOO_LONG: oversize_packets++;
                        default:     ;
                    endcase
                    if (want.command_match)
                        command_matches++;
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lwnxdf_pkg::*;
    import deframe_tb_pkg::*;

    localparam int unsigned MAX_PAYLOAD = 1019;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    wire  [47:0] m_tdata;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  cfg_data = 8'h00;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned results_checked;
    int unsigned good_packets;
    int unsigned crc_errors;
    int unsigned oversize_packets;
    int unsigned command_matches;

    bit          steady = 1'b0;     // no idling on either side while set
    int unsigned bytes_sent = 0;
    int unsigned settings_used = 0;
    logic [7:0]  wanted = 8'h00;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    lwnx_packet_deframer_crc16_unit #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    deframe_monitor #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) frame_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tdata          (s_tdata),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .m_tdata          (m_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .cfg_data         (cfg_data),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .mismatches       (mismatches),
        .pending          (pending),
        .results_checked  (results_checked),
        .good_packets     (good_packets),
        .crc_errors       (crc_errors),
        .oversize_packets (oversize_packets),
        .command_matches  (command_matches)
    );

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 34);
    end

    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata <= b;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // start byte, flags word, payload (command id first) and CRC; oversize
    // packets stop after the flags word as the parser drops back to hunting
    task automatic send_packet(input int unsigned len, input bit wr,
                               input logic [7:0] cmd, input bit spoil);
        logic [15:0] flags;
        logic [15:0] crc;
        logic [7:0]  b;
        flags = {len[9:0], 5'($urandom), wr};
        crc = crc_xmodem_step(16'h0000, START_BYTE);
        send_byte(START_BYTE);
        crc = crc_xmodem_step(crc, flags[7:0]);
        send_byte(flags[7:0]);
        crc = crc_xmodem_step(crc, flags[15:8]);
        send_byte(flags[15:8]);
        if (len + 2 > MAX_PAYLOAD)
            return;
        for (int i = 0; i < len; i++) begin
            b = (i == 0) ? cmd : 8'($urandom);
            crc = crc_xmodem_step(crc, b);
            send_byte(b);
        end
        if (spoil)
            crc = crc ^ (16'h0001 << $urandom_range(15));
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
    endtask

    task automatic write_wanted(input logic [7:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        wanted = v;
        settings_used++;
    endtask

    // wait for every outstanding result, then idle before returning
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic random_traffic(input int unsigned nbytes);
        int unsigned target;
        int unsigned pick;
        target = bytes_sent + nbytes;
        while (bytes_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            end else if (pick < 18) begin
                send_packet($urandom_range(1018, 1023), 1'($urandom), 8'h00, 1'b0);
            end else begin
                send_packet($urandom_range(0, 12), 1'($urandom),
                            $urandom_range(1) ? wanted : 8'($urandom),
                            $urandom_range(4) == 0);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_wanted(8'h3C);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_packet(0, 1'b1, 8'h00, 1'b0);   // empty payload: command id is CRC low byte
        send_packet(1, 1'b0, 8'h3C, 1'b0);
        send_packet(1, 1'b1, 8'h3C, 1'b1);   // right command, corrupted CRC
        send_packet(1018, 1'b0, 8'h00, 1'b0); // just over the limit
        send_packet(1023, 1'b1, 8'h00, 1'b0);
        settle();

        write_wanted(8'hFF);
        random_traffic(90);
        settle();

        write_wanted(8'h00);
        steady = 1'b1;
        random_traffic(90);
        settle();
        steady = 1'b0;

        write_wanted(8'($urandom));
        send_packet(12, 1'($urandom), wanted, 1'b0);
        random_traffic(90);
        settle();

        write_wanted(8'($urandom));
        random_traffic(90);
        settle();

        write_wanted(8'h80);
        random_traffic(90);
        settle();

        $display("Run covered %0d bytes / %0d results: %0d good (%0d matched), %0d CRC errors,",
                 bytes_sent, results_checked, good_packets, command_matches, crc_errors);
        $display("%0d oversize; wanted command set %0d times (0x00 and 0xFF among them).",
                 oversize_packets, settings_used);
        if (mismatches == 0 && pending == 0) begin
            $display("** lwnx_packet_deframer_crc16_unit: PASSED **");
        end else begin
            $display("** lwnx_packet_deframer_crc16_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d results outstanding", pending);
        $display("** lwnx_packet_deframer_crc16_unit: FAILED **");
        $finish;
    end

endmodule
